>>> hdl/wsenc_pkg.sv
`default_nettype none

package wsenc_pkg;

    localparam int NumOutBytes       = 14;
    localparam int QueueDepthDefault = 4;

    localparam logic [7:0] OpcodeCont   = 8'h80;
    localparam logic [7:0] OpcodeText   = 8'h81;
    localparam logic [7:0] OpcodeBinary = 8'h82;
    localparam logic [7:0] OpcodeClose  = 8'h88;
    localparam logic [7:0] OpcodePing   = 8'h89;
    localparam logic [7:0] OpcodePong   = 8'h8A;
    localparam logic [7:0] OpcodeNone   = 8'h00;
    localparam logic [7:0] MaskBit      = 8'h80;
    localparam logic [7:0] Len16Marker  = 8'h7E;
    localparam logic [7:0] Len64Marker  = 8'h7F;
    localparam logic [31:0] ShortLenLimit = 32'd126;
    localparam logic [31:0] Len16Limit    = 32'd65536;

    typedef enum logic [2:0] {
        FT_RAW     = 3'd0,
        FT_CONT    = 3'd1,
        FT_TEXT    = 3'd2,
        FT_BINARY  = 3'd3,
        FT_CLOSE   = 3'd4,
        FT_PING    = 3'd5,
        FT_PONG    = 3'd6,
        FT_INVALID = 3'd7
    } t_frame_type;

    typedef enum logic {
        OP_START = 1'b0,
        OP_DATA  = 1'b1
    } t_op;

    // one queue entry: a run of output bytes, emitted from index 0 upward
    typedef struct packed {
        logic [NumOutBytes-1:0][7:0] out_bytes;
        logic [3:0]                  count;
        logic                        final_last;
        logic                        err;
    } t_cmd;

    function automatic logic [7:0] opcode_of(input t_frame_type ft);
        logic [7:0] code;
        case (ft)
            FT_CONT:   code = OpcodeCont;
            FT_TEXT:   code = OpcodeText;
            FT_BINARY: code = OpcodeBinary;
            FT_CLOSE:  code = OpcodeClose;
            FT_PING:   code = OpcodePing;
            FT_PONG:   code = OpcodePong;
            default:   code = OpcodeNone;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> hdl/wsenc_front.sv
`default_nettype none

module wsenc_front
    import wsenc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_accept,
    input  wire logic        i_op,
    input  wire logic [2:0]  i_frame_type,
    input  wire logic [31:0] i_payload_length,
    input  wire logic        i_use_mask,
    input  wire logic [31:0] i_mask_key,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [31:0] r_bytes_left, n_bytes_left;
    logic [3:0][7:0] r_key, n_key;
    logic        r_mask_on, n_mask_on;
    logic [1:0]  r_kp, n_kp;

    t_frame_type ftype;
    logic [31:0] left_dec;
    logic [7:0]  mbit;
    logic [3:0][7:0] key_in;
    logic [3:0][7:0] len_b;

    assign ftype    = t_frame_type'(i_frame_type);
    assign left_dec = r_bytes_left - 32'd1;
    assign mbit     = i_use_mask ? MaskBit : 8'h00;
    assign key_in   = i_mask_key;
    assign len_b    = i_payload_length;

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_key        = r_key;
        n_mask_on    = r_mask_on;
        n_kp         = r_kp;
        o_push       = 1'b0;
        o_cmd        = '0;
        if (i_op == OP_DATA) begin
            o_push = 1'b1;
            o_cmd.count = 4'd1;
            if (r_bytes_left == 32'd0) begin
                o_cmd.final_last = 1'b1;
                o_cmd.err        = 1'b1;
            end else begin
                o_cmd.out_bytes[0] = r_mask_on ? (i_data_byte ^ r_key[2'd3 - r_kp])
                                               : i_data_byte;
                o_cmd.final_last = (left_dec == 32'd0);
                n_kp         = r_kp + 2'd1;
                n_bytes_left = left_dec;
            end
        end else begin
            n_kp = 2'd0;
            if (ftype == FT_INVALID) begin
                n_bytes_left     = '0;
                n_mask_on        = 1'b0;
                n_key            = '0;
                o_push           = 1'b1;
                o_cmd.count      = 4'd1;
                o_cmd.final_last = 1'b1;
                o_cmd.err        = 1'b1;
            end else if (ftype == FT_RAW) begin
                n_bytes_left = i_payload_length;
                n_mask_on    = 1'b0;
                n_key        = '0;
            end else begin
                n_bytes_left = i_payload_length;
                n_mask_on    = i_use_mask;
                n_key        = i_use_mask ? key_in : '0;
                o_push       = 1'b1;
                o_cmd.final_last   = (i_payload_length == 32'd0);
                o_cmd.out_bytes[0] = opcode_of(ftype);
                if (i_payload_length < ShortLenLimit) begin
                    o_cmd.out_bytes[1] = mbit | {1'b0, len_b[0][6:0]};
                    o_cmd.count        = 4'd2;
                    if (i_use_mask) begin
                        o_cmd.out_bytes[2] = key_in[3];
                        o_cmd.out_bytes[3] = key_in[2];
                        o_cmd.out_bytes[4] = key_in[1];
                        o_cmd.out_bytes[5] = key_in[0];
                        o_cmd.count        = 4'd6;
                    end
                end else if (i_payload_length < Len16Limit) begin
                    o_cmd.out_bytes[1] = mbit | Len16Marker;
                    o_cmd.out_bytes[2] = len_b[1];
                    o_cmd.out_bytes[3] = len_b[0];
                    o_cmd.count        = 4'd4;
                    if (i_use_mask) begin
                        o_cmd.out_bytes[4] = key_in[3];
                        o_cmd.out_bytes[5] = key_in[2];
                        o_cmd.out_bytes[6] = key_in[1];
                        o_cmd.out_bytes[7] = key_in[0];
                        o_cmd.count        = 4'd8;
                    end
                end else begin
                    o_cmd.out_bytes[1] = mbit | Len64Marker;
                    o_cmd.out_bytes[6] = len_b[3];
                    o_cmd.out_bytes[7] = len_b[2];
                    o_cmd.out_bytes[8] = len_b[1];
                    o_cmd.out_bytes[9] = len_b[0];
                    o_cmd.count        = 4'd10;
                    if (i_use_mask) begin
                        o_cmd.out_bytes[10] = key_in[3];
                        o_cmd.out_bytes[11] = key_in[2];
                        o_cmd.out_bytes[12] = key_in[1];
                        o_cmd.out_bytes[13] = key_in[0];
                        o_cmd.count         = 4'd14;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_key        <= '0;
            r_mask_on    <= 1'b0;
            r_kp         <= 2'd0;
        end else if (i_accept) begin
            r_bytes_left <= n_bytes_left;
            r_key        <= n_key;
            r_mask_on    <= n_mask_on;
            r_kp         <= n_kp;
        end
    end

endmodule

`default_nettype wire

>>> hdl/wsenc_queue.sv
`default_nettype none

module wsenc_queue
    import wsenc_pkg::*;
#(
    parameter int Depth = QueueDepthDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_ready,
    output logic      o_valid,
    output t_cmd      o_head,
    input  wire logic i_pop
);

    localparam int AW = $clog2(Depth);
    localparam int CW = $clog2(Depth + 1);
    localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
    localparam logic [CW-1:0] Full    = CW'(Depth);

    t_cmd          r_mem [Depth];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_ready = (r_cnt != Full);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LastIdx) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == LastIdx) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/wsenc_back.sv
`default_nettype none

module wsenc_back
    import wsenc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_cmd       i_head,
    output logic            o_pop,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_last,
    output logic            o_error
);

    logic [3:0] r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_err;
    logic       emit;
    logic       at_end;

    assign emit   = i_valid && (!r_valid || i_out_ready);
    assign at_end = (r_step == i_head.count - 4'd1);
    assign o_pop  = emit && at_end;

    assign o_out_valid = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last      = r_last;
    assign o_error     = r_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 4'd0;
            r_valid <= 1'b0;
            r_byte  <= '0;
            r_last  <= 1'b0;
            r_err   <= 1'b0;
        end else begin
            if (emit) begin
                r_valid <= 1'b1;
                r_byte  <= i_head.out_bytes[r_step];
                r_last  <= i_head.final_last && at_end;
                r_err   <= i_head.err;
                r_step  <= at_end ? 4'd0 : r_step + 4'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/websocket_frame_encoder_top.sv
// WebSocket frame encoder, server side. Each input transfer is a start item (op 0) or one
// payload byte (op 1); the encoded frame leaves as one byte per output transfer, with o_last
// on the final byte and o_error on a single error byte. Input transfers are taken back to
// back while the queue has room. A start item of a framed type gives 2 to 14 header bytes
// (opcode, length form, optional key), sent by the output stage at one byte per cycle while
// the output is ready; an invalid start gives a single error byte. A queue of QueueDepth
// entries between the classifying front end and that stage lets input keep flowing while a
// header drains, until the queue is full. Raw starts emit nothing.
`default_nettype none

module websocket_frame_encoder_top
    import wsenc_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_op,
    input  wire logic [2:0]  i_frame_type,
    input  wire logic [31:0] i_payload_length,
    input  wire logic        i_use_mask,
    input  wire logic [31:0] i_mask_key,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last,
    output logic             o_error
);

    logic q_ready;
    logic q_valid;
    logic accept;
    logic push;
    logic pop;
    t_cmd cmd;
    t_cmd head;

    assign o_in_ready = q_ready;
    assign accept     = i_in_valid && q_ready;

    wsenc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_op             (i_op),
        .i_frame_type     (i_frame_type),
        .i_payload_length (i_payload_length),
        .i_use_mask       (i_use_mask),
        .i_mask_key       (i_mask_key),
        .i_data_byte      (i_data_byte),
        .o_push           (push),
        .o_cmd            (cmd)
    );

    wsenc_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && push),
        .i_cmd   (cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_head  (head),
        .i_pop   (pop)
    );

    wsenc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

`default_nettype wire

>>> hdl/wsenc_checker.sv
`default_nettype none

module wsenc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  o_out_byte,
    input wire logic        o_last,
    input wire logic        o_error
);

    // a stalled input transfer stays offered
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid)
        else $error("input valid dropped while stalled");

    // a stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_last) && $stable(o_error))
        else $error("output payload changed while stalled");

    // an error byte always closes its frame
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_last)
        else $error("error byte without last");

    // an error byte carries zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_error |-> o_out_byte == 8'h00)
        else $error("error byte not zero");

    // nothing is offered right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind websocket_frame_encoder_top wsenc_checker u_wsenc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_byte  (o_out_byte),
    .o_last      (o_last),
    .o_error     (o_error)
);

`default_nettype wire

>>> test/websocket_frame_encoder_top_tb.sv
`timescale 1ns / 1ps

module websocket_frame_encoder_top_tb;
    import wsenc_pkg::*;

    typedef struct {
        t_op         op;
        t_frame_type ftype;
        logic [31:0] length;
        logic        use_mask;
        logic [31:0] key;
        logic [7:0]  data;
    } t_ws_item;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       err;
    } t_ws_byte;

    localparam int HoldOffAt     = 30;
    localparam int HoldOffCycles = 300;
    localparam int DrainCycles   = 40;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        i_op             = 1'b0;
    logic [2:0]  i_frame_type     = 3'd0;
    logic [31:0] i_payload_length = 32'd0;
    logic        i_use_mask       = 1'b0;
    logic [31:0] i_mask_key       = 32'd0;
    logic [7:0]  i_data_byte      = 8'd0;
    logic        i_out_ready      = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_last;
    logic        o_error;

    websocket_frame_encoder_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_op             (i_op),
        .i_frame_type     (i_frame_type),
        .i_payload_length (i_payload_length),
        .i_use_mask       (i_use_mask),
        .i_mask_key       (i_mask_key),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_last           (o_last),
        .o_error          (o_error)
    );

    // frame state of the encoder as predicted
    logic [31:0] frame_bytes_left = 32'd0;
    logic [31:0] frame_key        = 32'd0;
    logic        frame_masked     = 1'b0;
    logic [1:0]  key_idx          = 2'd0;

    t_ws_item pending_items[$];
    t_ws_byte encoded_bytes[$];

    t_ws_item cur_item;
    int total_items   = 0;
    int inputs_taken  = 0;
    int starts_taken  = 0;
    int bytes_checked = 0;
    int errors_seen   = 0;
    int failures      = 0;
    int drv_wait      = 0;
    int drv_quiet     = 0;
    int rcv_wait      = 0;
    int rcv_quiet     = 0;
    bit hold_off_done = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            quiet = $urandom_range(10, 25);
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic logic [7:0] frame_opcode(input t_frame_type ft);
        case (ft)
            FT_CONT:   return OpcodeCont;
            FT_TEXT:   return OpcodeText;
            FT_BINARY: return OpcodeBinary;
            FT_CLOSE:  return OpcodeClose;
            FT_PING:   return OpcodePing;
            FT_PONG:   return OpcodePong;
            default:   return OpcodeNone;
        endcase
    endfunction

    task automatic push_byte(input logic [7:0] value, input logic last, input logic err);
        t_ws_byte b;
        b.value = value;
        b.last  = last;
        b.err   = err;
        encoded_bytes.push_back(b);
    endtask

    // works out the bytes that one input item produces
    task automatic encode_item(input t_ws_item it);
        logic [7:0] hdr[$];
        logic [7:0] mbit;
        logic [7:0] b;
        int sh;
        if (it.op == OP_DATA) begin
            if (frame_bytes_left == 32'd0) begin
                push_byte(8'h00, 1'b1, 1'b1);
            end else begin
                b = it.data;
                if (frame_masked) begin
                    sh = 3 - int'(key_idx);
                    b = b ^ frame_key[8*sh +: 8];
                end
                key_idx = key_idx + 2'd1;
                frame_bytes_left = frame_bytes_left - 32'd1;
                push_byte(b, frame_bytes_left == 32'd0, 1'b0);
            end
        end else begin
            key_idx = 2'd0;
            if (it.ftype == FT_INVALID) begin
                frame_bytes_left = 32'd0;
                frame_masked     = 1'b0;
                frame_key        = 32'd0;
                push_byte(OpcodeNone, 1'b1, 1'b1);
            end else begin
                frame_bytes_left = it.length;
                if (it.ftype == FT_RAW) begin
                    frame_masked = 1'b0;
                    frame_key    = 32'd0;
                end else begin
                    frame_masked = it.use_mask;
                    frame_key    = it.use_mask ? it.key : 32'd0;
                    mbit = it.use_mask ? MaskBit : 8'h00;
                    hdr.push_back(frame_opcode(it.ftype));
                    if (it.length < ShortLenLimit) begin
                        hdr.push_back(mbit | it.length[7:0]);
                    end else if (it.length < Len16Limit) begin
                        hdr.push_back(mbit | Len16Marker);
                        hdr.push_back(it.length[15:8]);
                        hdr.push_back(it.length[7:0]);
                    end else begin
                        hdr.push_back(mbit | Len64Marker);
                        repeat (4) hdr.push_back(8'h00);
                        hdr.push_back(it.length[31:24]);
                        hdr.push_back(it.length[23:16]);
                        hdr.push_back(it.length[15:8]);
                        hdr.push_back(it.length[7:0]);
                    end
                    if (it.use_mask) begin
                        hdr.push_back(it.key[31:24]);
                        hdr.push_back(it.key[23:16]);
                        hdr.push_back(it.key[15:8]);
                        hdr.push_back(it.key[7:0]);
                    end
                    foreach (hdr[i]) begin
                        push_byte(hdr[i], (it.length == 32'd0) && (i == hdr.size() - 1), 1'b0);
                    end
                end
            end
        end
    endtask

    task automatic add_start(input t_frame_type ft, input logic [31:0] len, input logic msk,
                             input logic [31:0] key);
        t_ws_item it;
        it.op       = OP_START;
        it.ftype    = ft;
        it.length   = len;
        it.use_mask = msk;
        it.key      = key;
        it.data     = 8'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic add_data(input logic [7:0] value);
        t_ws_item it;
        it.op       = OP_DATA;
        it.ftype    = t_frame_type'($urandom_range(0, 7));
        it.length   = $urandom;
        it.use_mask = 1'($urandom);
        it.key      = $urandom;
        it.data     = value;
        pending_items.push_back(it);
    endtask

    task automatic check_field(input string name, input logic [7:0] expv, input logic [7:0] act);
        if (act !== expv) begin
            $display("%0t mismatch on %s: expected %h actual %h", $realtime, name, expv, act);
            failures++;
        end
    endtask

    // driver: input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                inputs_taken++;
                if (cur_item.op == OP_START) starts_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (drv_wait > 0) begin
                    drv_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    encode_item(cur_item);
                    i_op             <= cur_item.op;
                    i_frame_type     <= cur_item.ftype;
                    i_payload_length <= cur_item.length;
                    i_use_mask       <= cur_item.use_mask;
                    i_mask_key       <= cur_item.key;
                    i_data_byte      <= cur_item.data;
                    i_in_valid       <= 1'b1;
                    drv_wait = draw_gap(drv_quiet);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: output side
    always @(posedge i_clk) begin
        t_ws_byte e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (encoded_bytes.size() == 0) begin
                    $display("%0t unexpected transfer: expected none actual byte %h last %b error %b",
                             $realtime, o_out_byte, o_last, o_error);
                    failures++;
                end else begin
                    e = encoded_bytes.pop_front();
                    check_field("out_byte", e.value, o_out_byte);
                    check_field("last", {7'd0, e.last}, {7'd0, o_last});
                    check_field("error", {7'd0, e.err}, {7'd0, o_error});
                    if (e.err) errors_seen++;
                end
                bytes_checked++;
                rcv_wait = draw_gap(rcv_quiet);
                if (!hold_off_done && bytes_checked == HoldOffAt) begin
                    rcv_wait = HoldOffCycles;
                    hold_off_done = 1'b1;
                end
            end
            if (rcv_wait > 0) begin
                rcv_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int n_rand;
        int len;
        int kind;
        int cls;
        // directed part
        add_data(8'hFF);
        add_start(FT_INVALID, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_start(FT_RAW, 32'd0, 1'b0, 32'd0);
        add_start(FT_RAW, 32'd2, 1'b1, 32'hFFFF_FFFF);
        add_data(8'h00);
        add_data(8'hFF);
        add_start(FT_TEXT, 32'd0, 1'b0, 32'h1234_5678);
        add_start(FT_BINARY, 32'd0, 1'b1, 32'hDEAD_BEEF);
        add_start(FT_CONT, 32'd125, 1'b1, 32'h0102_0304);
        add_data(8'h00);
        add_data(8'hFF);
        add_start(FT_PING, 32'd126, 1'b0, 32'd0);
        add_start(FT_PONG, 32'd65535, 1'b1, 32'h8040_2010);
        add_start(FT_CLOSE, 32'd65536, 1'b0, 32'd0);
        add_start(FT_CONT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        add_data(8'h5A);
        add_start(FT_INVALID, 32'd3, 1'b0, 32'd0);
        add_data(8'h77);
        add_start(FT_CLOSE, 32'd5, 1'b1, 32'hA5C3_3C5A);
        repeat (5) add_data(8'($urandom));

        // random part, mostly complete frames
        n_rand = 0;
        while (n_rand < 82) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
                add_start(t_frame_type'($urandom_range(0, 6)), len, 1'($urandom), $urandom);
                repeat (len) add_data(8'($urandom));
                n_rand += len + 1;
            end else if (kind == 7) begin
                cls = $urandom_range(0, 2);
                add_start(t_frame_type'($urandom_range(0, 6)),
                          (cls == 0) ? 32'($urandom_range(126, 65535)) :
                          (cls == 1) ? 32'($urandom_range(65536, 32'hFFFF_FFFF)) : $urandom,
                          1'($urandom), $urandom);
                len = $urandom_range(0, 3);
                repeat (len) add_data(8'($urandom));
                n_rand += len + 1;
            end else if (kind == 8) begin
                add_start(t_frame_type'($urandom_range(0, 6)), $urandom_range(4, 12),
                          1'($urandom), $urandom);
                len = $urandom_range(0, 3);
                repeat (len) add_data(8'($urandom));
                add_start(FT_INVALID, $urandom, 1'($urandom), $urandom);
                n_rand += len + 2;
            end else begin
                len = $urandom_range(1, 3);
                repeat (len) add_data(8'($urandom));
                n_rand += len;
            end
        end
        total_items = pending_items.size();

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (inputs_taken < total_items) @(posedge i_clk);
        while (encoded_bytes.size() > 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (encoded_bytes.size() > 0) begin
            $display("%0t %0d expected bytes never arrived", $realtime, encoded_bytes.size());
            failures++;
        end

        $display("covered %0d input transfers: %0d frame starts and %0d payload bytes",
                 inputs_taken, starts_taken, inputs_taken - starts_taken);
        $display("checked %0d output bytes, %0d of them error results, %0d mismatches",
                 bytes_checked, errors_seen, failures);
        if (failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t timeout with %0d inputs taken and %0d bytes outstanding",
                 $realtime, inputs_taken, encoded_bytes.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
